/* rtl/uets_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_pkg
// Shared constants, types and helpers of the endpoint transfer segmenter.
// ----------------------------------------------------------------------------
package uets_pkg;

  localparam int ENDPOINTS = 10;
  localparam int SLOTS     = ENDPOINTS + 1;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int LEN_W     = 16;
  localparam int PKT_W     = 11;
  localparam int EP_W      = 4;

  // slot that holds the endpoint 0 IN context
  localparam logic [SLOT_W-1:0] EP0_IN_SLOT = SLOT_W'(ENDPOINTS);

  // event codes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_OUT   = 2'd1;
  localparam logic [1:0] MODE_TX    = 2'd2;
  localparam logic [1:0] MODE_RSV   = 2'd3;

  typedef struct packed {
    logic [1:0]       mode;
    logic [EP_W-1:0]  endpoint;
    logic             direction_in;
    logic [LEN_W-1:0] transfer_len;
    logic [PKT_W-1:0] max_packet;
    logic [PKT_W-1:0] packet_bytes;
  } item_t;

  typedef struct packed {
    logic [PKT_W-1:0] move_bytes;
    logic [LEN_W-1:0] buffer_offset;
    logic             send_packet;
    logic             transfer_done;
    logic [LEN_W-1:0] done_length;
    logic             done_direction_in;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0] total;
    logic [LEN_W-1:0] done;
    logic [PKT_W-1:0] psize;
  } ctx_t;

  // context slot an event works on
  function automatic logic [SLOT_W-1:0] slot_of(input item_t it);
    logic ep0;
    ep0 = (it.endpoint == '0);
    if (ep0 && ((it.mode == MODE_TX) || ((it.mode == MODE_START) && it.direction_in))) begin
      return EP0_IN_SLOT;
    end
    return SLOT_W'(it.endpoint);
  endfunction

endpackage

/* rtl/uets_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_in_if
// Event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
interface uets_in_if;
  import uets_pkg::*;

  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [EP_W-1:0]  endpoint;
  logic             direction_in;
  logic [LEN_W-1:0] transfer_len;
  logic [PKT_W-1:0] max_packet;
  logic [PKT_W-1:0] packet_bytes;

  modport source (
    output valid, mode, endpoint, direction_in, transfer_len, max_packet, packet_bytes,
    input  ready
  );
  modport sink (
    input  valid, mode, endpoint, direction_in, transfer_len, max_packet, packet_bytes,
    output ready
  );
endinterface

/* rtl/uets_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface uets_out_if;
  import uets_pkg::*;

  logic             valid;
  logic             ready;
  logic [PKT_W-1:0] move_bytes;
  logic [LEN_W-1:0] buffer_offset;
  logic             send_packet;
  logic             transfer_done;
  logic [LEN_W-1:0] done_length;
  logic             done_direction_in;

  modport source (
    output valid, move_bytes, buffer_offset, send_packet, transfer_done, done_length,
           done_direction_in,
    input  ready
  );
  modport sink (
    input  valid, move_bytes, buffer_offset, send_packet, transfer_done, done_length,
           done_direction_in,
    output ready
  );
endinterface

/* rtl/uets_ctx_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_ctx_mem
// Transfer context memory, one read and one write port, registered read.
// Per-slot valid bits make unwritten slots read as zero after reset.
// ----------------------------------------------------------------------------
module uets_ctx_mem
  import uets_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic [uets_pkg::SLOT_W-1:0]  raddr,
  output uets_pkg::ctx_t               rdata,
  input  logic                         we,
  input  logic [uets_pkg::SLOT_W-1:0]  waddr,
  input  uets_pkg::ctx_t               wdata
);

  ctx_t             mem [SLOTS];
  logic [SLOTS-1:0] vld;
  ctx_t             rd_q;
  logic             rd_vld;

  // storage write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_q   <= mem[raddr];
    rd_vld <= vld[raddr];
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

/* rtl/uets_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uets_step
// Context update: computes the result of one event and the new context.
// ----------------------------------------------------------------------------
module uets_step
  import uets_pkg::*;
(
  input  uets_pkg::item_t  item,
  input  uets_pkg::ctx_t   ctx_rd,
  output uets_pkg::res_t   res,
  output logic             wr_en,
  output uets_pkg::ctx_t   ctx_wr
);

  ctx_t             start_ctx;
  ctx_t             rel_src;
  logic [LEN_W-1:0] rel_remain;
  logic [PKT_W-1:0] rel_len;
  logic [LEN_W-1:0] rel_done;
  logic             ep_ok;

  // packet release on either the freshly armed or the stored context
  always_comb begin
    start_ctx.total = item.transfer_len;
    start_ctx.done  = '0;
    start_ctx.psize = item.max_packet;
    rel_src         = (item.mode == MODE_START) ? start_ctx : ctx_rd;
    rel_remain      = rel_src.total - rel_src.done;
    if (rel_remain > LEN_W'(rel_src.psize)) begin
      rel_len = rel_src.psize;
    end else begin
      rel_len = rel_remain[PKT_W-1:0];
    end
    rel_done = rel_src.done + LEN_W'(rel_len);
  end

  assign ep_ok = (32'(item.endpoint) < ENDPOINTS);

  // event decode
  always_comb begin
    logic [PKT_W-1:0] cnt;
    logic [LEN_W-1:0] out_done;
    logic [PKT_W-1:0] out_move;
    res      = '0;
    wr_en    = 1'b0;
    ctx_wr   = ctx_rd;
    cnt      = item.packet_bytes;
    out_done = ctx_rd.done;
    out_move = '0;
    if (ep_ok) begin
      unique case (item.mode)
        MODE_START: begin
          wr_en  = 1'b1;
          ctx_wr = start_ctx;
          if (item.direction_in) begin
            ctx_wr.done       = rel_done;
            res.move_bytes    = rel_len;
            res.send_packet   = 1'b1;
          end
        end
        MODE_OUT: begin
          // clamp the received count to what remains
          if ((cnt != '0) && (ctx_rd.total != '0)) begin
            if (LEN_W'(cnt) > rel_remain) begin
              cnt = rel_remain[PKT_W-1:0];
            end
            out_move = cnt;
            out_done = ctx_rd.done + LEN_W'(cnt);
          end
          wr_en             = 1'b1;
          ctx_wr.done       = out_done;
          res.move_bytes    = out_move;
          res.buffer_offset = ctx_rd.done;
          if ((cnt < ctx_rd.psize) || (out_done == ctx_rd.total)) begin
            res.transfer_done = 1'b1;
            res.done_length   = (item.endpoint == '0) ? ctx_rd.total : out_done;
          end
        end
        MODE_TX: begin
          if (ctx_rd.total != ctx_rd.done) begin
            wr_en             = 1'b1;
            ctx_wr.done       = rel_done;
            res.move_bytes    = rel_len;
            res.buffer_offset = ctx_rd.done;
            res.send_packet   = 1'b1;
          end else begin
            res.buffer_offset     = ctx_rd.done;
            res.transfer_done     = 1'b1;
            res.done_length       = ctx_rd.total;
            res.done_direction_in = 1'b1;
          end
        end
        MODE_RSV: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

endmodule

/* rtl/usb_endpoint_transfer_segmenter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_endpoint_transfer_segmenter_core
// Per-endpoint transfer length tracking and IN/OUT packet segmentation.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one event per transfer: start, OUT packet received or IN
//   bank ready. out_ch returns exactly one result per event: bytes to move,
//   buffer offset, packet release and completion report.
//   Contexts (total, done, packet size) sit in a small synchronous memory
//   with one slot per endpoint plus one for endpoint 0 IN.
// Sequencing:
//   an event is read out of the context memory on the cycle it is accepted,
//   then updated and written back, with its result registered on out_ch,
//   once the output register is free; in_ch.ready stays low until then, so
//   a new event is taken only after the previous one is written back.
// Reset:
//   rst clears the handshake state and marks all contexts as zero.
// Stall:
//   a result waits in the output register while out_ch.ready is low; one
//   further event is taken meanwhile and holds in the update stage until
//   the output register frees.
// ----------------------------------------------------------------------------
module usb_endpoint_transfer_segmenter_core
  import uets_pkg::*;
(
  input  logic clk,
  input  logic rst,
  uets_in_if.sink    in_ch,
  uets_out_if.source out_ch
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic              state;
  logic              state_next;
  item_t             item_in;
  item_t             item;
  logic [SLOT_W-1:0] raddr;
  ctx_t              ctx_rd;
  ctx_t              ctx_wr;
  res_t              res;
  res_t              out_q;
  logic              out_valid;
  logic              upd_en;
  logic              wr_en;
  logic              accept;
  logic              load;

  // input payload
  always_comb begin
    item_in.mode         = in_ch.mode;
    item_in.endpoint     = in_ch.endpoint;
    item_in.direction_in = in_ch.direction_in;
    item_in.transfer_len = in_ch.transfer_len;
    item_in.max_packet   = in_ch.max_packet;
    item_in.packet_bytes = in_ch.packet_bytes;
  end

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load        = (state == ST_CALC) && (!out_valid || out_ch.ready);
  assign upd_en      = load && wr_en;

  // hold the event under work
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
  end

  // read the context of the incoming event, or keep reading the held one
  assign raddr = accept ? slot_of(item_in) : slot_of(item);

  uets_ctx_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .rdata (ctx_rd),
    .we    (upd_en),
    .waddr (slot_of(item)),
    .wdata (ctx_wr)
  );

  uets_step u_step (
    .item   (item),
    .ctx_rd (ctx_rd),
    .res    (res),
    .wr_en  (wr_en),
    .ctx_wr (ctx_wr)
  );

  // control sequence
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_CALC;
      ST_CALC: if (load) state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_q <= res;
    end
  end

  assign out_ch.valid             = out_valid;
  assign out_ch.move_bytes        = out_q.move_bytes;
  assign out_ch.buffer_offset     = out_q.buffer_offset;
  assign out_ch.send_packet       = out_q.send_packet;
  assign out_ch.transfer_done     = out_q.transfer_done;
  assign out_ch.done_length       = out_q.done_length;
  assign out_ch.done_direction_in = out_q.done_direction_in;

  // checks
  a_accept_to_calc: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_CALC))
    else $error("accepted event did not enter update stage");

  a_load_gives_result: assert property (@(posedge clk) disable iff (rst)
    load |=> out_ch.valid)
    else $error("update stage finished without a result");

  a_write_only_on_load: assert property (@(posedge clk) disable iff (rst)
    upd_en |-> (state == ST_CALC) && !accept)
    else $error("context written outside update stage");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CALC) && !load |=> !in_ch.ready)
    else $error("new event taken while one is still pending");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the endpoint transfer segmenter against a cycle-free model of its
// context table. Directed cases hit zero-length, clamped, short-packet and
// ignored events. Random transfers follow, mostly well formed, mixed with noise.
// The sender pauses at random and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import uets_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 600;
  localparam int TAIL_CYCLES  = 10;
  localparam int REPORT_MAX   = 40;

  typedef struct {
    item_t ev;
    bit    drain;
  } queued_event_t;

  logic clk = 1'b0;
  logic rst;

  uets_in_if  ev_ch();
  uets_out_if res_ch();

  usb_endpoint_transfer_segmenter_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (ev_ch),
    .out_ch (res_ch)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // model of the context table
  logic [LEN_W-1:0] ctx_total [SLOTS];
  logic [LEN_W-1:0] ctx_done  [SLOTS];
  logic [PKT_W-1:0] ctx_psize [SLOTS];

  queued_event_t pending_events[$];
  res_t          expected_results[$];

  bit          hold_for_drain = 1'b0;
  int unsigned live_queued = 0;
  int unsigned events_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_start = 0, n_out = 0, n_tx = 0, n_ignored = 0;
  int unsigned n_sent = 0, n_complete = 0;
  logic        in_taken = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  logic [15:0] ready_pat = '1;
  int unsigned ready_phase = 0;
  logic        calm;

  assign calm = (events_accepted >= 250) && (events_accepted < 350);

  // next IN packet of a slot: at most one packet size of what is left
  function automatic res_t release_packet(input int unsigned s);
    res_t             r;
    logic [LEN_W-1:0] left;
    r = '0;
    left = ctx_total[s] - ctx_done[s];
    if (left > ctx_psize[s]) left = ctx_psize[s];
    r.move_bytes    = left[PKT_W-1:0];
    r.buffer_offset = ctx_done[s];
    r.send_packet   = 1'b1;
    ctx_done[s] = ctx_done[s] + left;
    return r;
  endfunction

  // update the context an event touches and return its result
  function automatic res_t advance_context(input item_t ev);
    res_t             r;
    int unsigned      s;
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] remain;
    logic [PKT_W-1:0] cnt;
    logic [PKT_W-1:0] mv;
    r = '0;
    if (ev.endpoint >= ENDPOINTS || ev.mode == MODE_RSV) return r;
    case (ev.mode)
      MODE_START: begin
        s = (ev.endpoint == 0 && ev.direction_in) ? ENDPOINTS : ev.endpoint;
        ctx_total[s] = ev.transfer_len;
        ctx_done[s]  = '0;
        ctx_psize[s] = ev.max_packet;
        if (ev.direction_in) r = release_packet(s);
      end
      MODE_OUT: begin
        s = ev.endpoint;
        offset = ctx_done[s];
        cnt = ev.packet_bytes;
        mv = '0;
        // clamp to what remains, only for a nonempty packet of a nonempty transfer
        if (cnt != 0 && ctx_total[s] != 0) begin
          remain = ctx_total[s] - offset;
          if (cnt > remain) cnt = remain[PKT_W-1:0];
          mv = cnt;
          ctx_done[s] = offset + mv;
        end
        r.move_bytes    = mv;
        r.buffer_offset = offset;
        if (cnt < ctx_psize[s] || ctx_done[s] == ctx_total[s]) begin
          r.transfer_done = 1'b1;
          r.done_length   = (ev.endpoint == 0) ? ctx_total[s] : ctx_done[s];
        end
      end
      default: begin
        s = (ev.endpoint == 0) ? ENDPOINTS : ev.endpoint;
        if (ctx_total[s] != ctx_done[s]) begin
          r = release_packet(s);
        end else begin
          r.buffer_offset     = ctx_done[s];
          r.transfer_done     = 1'b1;
          r.done_length       = ctx_total[s];
          r.done_direction_in = 1'b1;
        end
      end
    endcase
    return r;
  endfunction

  task automatic queue_event(input logic [1:0] mode, input int unsigned ep,
                             input int unsigned dir, input int unsigned total,
                             input int unsigned maxp, input int unsigned cnt);
    queued_event_t q;
    q.ev.mode         = mode;
    q.ev.endpoint     = EP_W'(ep);
    q.ev.direction_in = dir[0];
    q.ev.transfer_len = LEN_W'(total);
    q.ev.max_packet   = PKT_W'(maxp);
    q.ev.packet_bytes = PKT_W'(cnt);
    q.drain = hold_for_drain;
    hold_for_drain = 1'b0;
    pending_events.push_back(q);
    if (q.ev.endpoint < ENDPOINTS && mode != MODE_RSV) live_queued++;
  endtask

  task automatic queue_noise();
    queue_event(2'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 1),
                $urandom, $urandom, $urandom);
  endtask

  // event driver and result ready pattern, both on the falling edge
  always @(negedge clk) begin : drive
    queued_event_t q;
    if (rst) begin
      ev_ch.valid   <= 1'b0;
      res_ch.ready  <= 1'b0;
      gap_left = 0;
      burst_left = 1;
    end else begin
      // event side: hold until the current transfer is taken
      if (!(ev_ch.valid && !in_taken)) begin
        if (gap_left > 0) begin
          gap_left--;
          ev_ch.valid <= 1'b0;
        end else if (pending_events.size() == 0 ||
                     (pending_events[0].drain && expected_results.size() != 0)) begin
          ev_ch.valid <= 1'b0;
        end else begin
          q = pending_events.pop_front();
          ev_ch.valid        <= 1'b1;
          ev_ch.mode         <= q.ev.mode;
          ev_ch.endpoint     <= q.ev.endpoint;
          ev_ch.direction_in <= q.ev.direction_in;
          ev_ch.transfer_len <= q.ev.transfer_len;
          ev_ch.max_packet   <= q.ev.max_packet;
          ev_ch.packet_bytes <= q.ev.packet_bytes;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = (calm || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      // result side: ready patterns from a 16-bit word, redrawn each round
      if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        res_ch.ready <= ready_pat[ready_phase];
        if (ready_phase == 15) begin
          ready_phase = 0;
          case ($urandom_range(0, 3))
            0: ready_pat = '1;
            1: ready_pat = 16'($urandom);
            2: ready_pat = 16'($urandom | $urandom);
            default: ready_pat = 16'($urandom & $urandom);
          endcase
        end else begin
          ready_phase++;
        end
      end
    end
  end

  // monitor: predict on event transfers, check on result transfers
  always @(posedge clk) begin : monitor
    item_t ev;
    res_t  want;
    res_t  got;
    in_taken <= ev_ch.valid && ev_ch.ready && !rst;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (ev_ch.valid && ev_ch.ready) begin
        ev.mode         = ev_ch.mode;
        ev.endpoint     = ev_ch.endpoint;
        ev.direction_in = ev_ch.direction_in;
        ev.transfer_len = ev_ch.transfer_len;
        ev.max_packet   = ev_ch.max_packet;
        ev.packet_bytes = ev_ch.packet_bytes;
        want = advance_context(ev);
        expected_results.push_back(want);
        events_accepted++;
        if (ev.endpoint >= ENDPOINTS || ev.mode == MODE_RSV) n_ignored++;
        else if (ev.mode == MODE_START) n_start++;
        else if (ev.mode == MODE_OUT) n_out++;
        else n_tx++;
        if (want.send_packet) n_sent++;
        if (want.transfer_done) n_complete++;
      end
      if (res_ch.valid && res_ch.ready) begin
        got.move_bytes        = res_ch.move_bytes;
        got.buffer_offset     = res_ch.buffer_offset;
        got.send_packet       = res_ch.send_packet;
        got.transfer_done     = res_ch.transfer_done;
        got.done_length       = res_ch.done_length;
        got.done_direction_in = res_ch.done_direction_in;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_MAX) begin
              if (got.move_bytes !== want.move_bytes)
                $display("%0t: move_bytes expected %0d actual %0d",
                         $time, want.move_bytes, got.move_bytes);
              if (got.buffer_offset !== want.buffer_offset)
                $display("%0t: buffer_offset expected %0d actual %0d",
                         $time, want.buffer_offset, got.buffer_offset);
              if (got.send_packet !== want.send_packet)
                $display("%0t: send_packet expected %0b actual %0b",
                         $time, want.send_packet, got.send_packet);
              if (got.transfer_done !== want.transfer_done)
                $display("%0t: transfer_done expected %0b actual %0b",
                         $time, want.transfer_done, got.transfer_done);
              if (got.done_length !== want.done_length)
                $display("%0t: done_length expected %0d actual %0d",
                         $time, want.done_length, got.done_length);
              if (got.done_direction_in !== want.done_direction_in)
                $display("%0t: done_direction_in expected %0b actual %0b",
                         $time, want.done_direction_in, got.done_direction_in);
            end
          end
        end
      end
      // watchdog on transfer activity
      if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned ep, dir, psz, tot, left, cnt, npkt, k, base;
    bit          mid_drain;
    rst = 1'b1;
    ev_ch.valid        = 1'b0;
    ev_ch.mode         = MODE_START;
    ev_ch.endpoint     = '0;
    ev_ch.direction_in = 1'b0;
    ev_ch.transfer_len = '0;
    ev_ch.max_packet   = '0;
    ev_ch.packet_bytes = '0;
    res_ch.ready       = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      ctx_total[i] = '0;
      ctx_done[i]  = '0;
      ctx_psize[i] = '0;
    end

    // endpoint 0 IN bank ready before any start: completes at once
    queue_event(MODE_TX, 0, 1, 0, 0, 0);
    // zero-length IN transfer on endpoint 0
    queue_event(MODE_START, 0, 1, 0, 64, 0);
    queue_event(MODE_TX, 0, 0, 0, 0, 0);
    // IN transfer of one full and one short packet
    queue_event(MODE_START, 0, 1, 100, 64, 0);
    queue_event(MODE_TX, 0, 1, 0, 0, 0);
    queue_event(MODE_TX, 0, 1, 0, 0, 0);
    // endpoint 0 OUT: last packet overruns, gets clamped, total reported
    queue_event(MODE_START, 0, 0, 130, 64, 0);
    queue_event(MODE_OUT, 0, 0, 0, 0, 64);
    queue_event(MODE_OUT, 0, 0, 0, 0, 64);
    queue_event(MODE_OUT, 0, 0, 0, 0, 10);
    // OUT ends on a short packet, bytes received reported; then one more packet
    queue_event(MODE_START, 3, 0, 200, 64, 0);
    queue_event(MODE_OUT, 3, 0, 0, 0, 64);
    queue_event(MODE_OUT, 3, 0, 0, 0, 20);
    queue_event(MODE_OUT, 3, 0, 0, 0, 0);
    // empty OUT transfer: nothing moves even for the largest count
    queue_event(MODE_START, 5, 0, 0, 8, 2047);
    queue_event(MODE_OUT, 5, 1, 65535, 2047, 2047);
    // largest transfer with the largest legal packet size
    queue_event(MODE_START, 9, 1, 65535, 1024, 0);
    queue_event(MODE_TX, 9, 0, 0, 0, 0);
    // zero packet size gives zero-length packets forever
    queue_event(MODE_START, 2, 1, 50, 0, 0);
    queue_event(MODE_TX, 2, 1, 0, 0, 0);
    // packet size beyond the legal range
    queue_event(MODE_START, 7, 0, 65535, 2047, 0);
    queue_event(MODE_OUT, 7, 0, 0, 0, 2047);
    // ignored: endpoint out of range, reserved mode
    queue_event(MODE_START, 10, 1, 100, 64, 0);
    queue_event(MODE_OUT, 15, 1, 65535, 2047, 2047);
    queue_event(MODE_RSV, 1, 1, 65535, 2047, 2047);

    // random transfers with noise; sender drains before the first and midway
    base = live_queued;
    mid_drain = 1'b0;
    hold_for_drain = 1'b1;
    while (live_queued < base + RANDOM_ITEMS) begin
      if (!mid_drain && live_queued >= base + RANDOM_ITEMS / 2) begin
        hold_for_drain = 1'b1;
        mid_drain = 1'b1;
      end
      if ($urandom_range(0, 5) == 0) begin
        queue_noise();
      end else begin
        ep  = $urandom_range(0, ENDPOINTS - 1);
        dir = $urandom_range(0, 1);
        case ($urandom_range(0, 19))
          0:             psz = 0;
          1:             psz = $urandom_range(1025, 2047);
          2, 3, 4, 5, 6: psz = 8 << $urandom_range(0, 7);
          default:       psz = $urandom_range(8, 1024);
        endcase
        case ($urandom_range(0, 9))
          0:       tot = 0;
          1:       tot = $urandom_range(0, 65535);
          2, 3:    tot = (psz * $urandom_range(1, 4)) & 16'hFFFF;
          default: tot = $urandom_range(0, 4 * psz + 7);
        endcase
        queue_event(MODE_START, ep, dir, tot, psz, $urandom_range(0, 2047));
        if (dir != 0) begin
          // one bank-ready per remaining packet plus the completing one
          npkt = (psz == 0) ? 3 : (tot + psz - 1) / psz;
          if (npkt == 0) npkt = 1;
          npkt += $urandom_range(0, 1);
          if (npkt > 10) npkt = 10;
          for (k = 0; k < npkt; k++) begin
            if ($urandom_range(0, 11) == 0) queue_noise();
            queue_event(MODE_TX, ep, $urandom_range(0, 1), $urandom, $urandom, $urandom);
          end
        end else begin
          left = tot;
          for (k = 0; k < 10; k++) begin
            if ($urandom_range(0, 7) == 0) cnt = $urandom_range(0, 2047);
            else if (left > psz) cnt = psz;
            else if ($urandom_range(0, 3) == 0) cnt = $urandom_range(0, left);
            else cnt = left;
            if ($urandom_range(0, 11) == 0) queue_noise();
            queue_event(MODE_OUT, ep, $urandom_range(0, 1), $urandom, $urandom, cnt);
            if (cnt < psz || cnt >= left) break;
            left -= cnt;
          end
        end
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // wait for every event taken and every result checked
    while ((pending_events.size() != 0 || ev_ch.valid || expected_results.size() != 0) &&
           idle_cycles < IDLE_LIMIT)
      @(negedge clk);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("usb_endpoint_transfer_segmenter_core: mismatch");
    end else begin
      repeat (TAIL_CYCLES) @(negedge clk);
      if (expected_results.size() != 0) begin
        errors++;
        $display("%0t: %0d results never arrived", $time, expected_results.size());
      end
      $display("run: %0d starts, %0d OUT packets, %0d bank-ready events, %0d ignored events",
               n_start, n_out, n_tx, n_ignored);
      $display("run: %0d IN packets released, %0d completions, %0d results checked",
               n_sent, n_complete, results_checked);
      if (errors == 0) begin
        $display("usb_endpoint_transfer_segmenter_core: match");
      end else begin
        $display("usb_endpoint_transfer_segmenter_core: mismatch");
      end
    end
    $finish;
  end

endmodule
